// ----- design/scr_pkg.sv -----
// Package for the serial command-line recognizer.
// Holds the beat types, command and action codes, keywords and the keyword match function.
// No dependencies.
package scr_pkg;

	localparam int LINE_LEN         = 5;
	localparam int NUM_SONGS        = 6;
	localparam int TICKS_PER_SECOND = 100000;

	localparam int LEN_W   = $clog2(LINE_LEN + 1);
	localparam int TICK_W  = 17;
	localparam int SONG_W  = 3;
	localparam int KW_MAX  = 8;

	localparam logic [2:0] CMD_BYTE    = 3'd0;
	localparam logic [2:0] CMD_TICK    = 3'd1;
	localparam logic [2:0] CMD_PAUSE   = 3'd2;
	localparam logic [2:0] CMD_UNPAUSE = 3'd3;
	localparam logic [2:0] CMD_PLAY    = 3'd4;

	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_HELP    = 3'd1;
	localparam logic [2:0] ACT_PLAY    = 3'd2;
	localparam logic [2:0] ACT_PAUSE   = 3'd3;
	localparam logic [2:0] ACT_LOAD    = 3'd4;
	localparam logic [2:0] ACT_STOP    = 3'd5;
	localparam logic [2:0] ACT_INVALID = 3'd6;

	localparam logic [7:0] CH_NUL = 8'd0;
	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_DEL = 8'd127;

	localparam logic [TICK_W-1:0] TICK_LIMIT = TICK_W'(TICKS_PER_SECOND);
	localparam logic [SONG_W-1:0] SONG_LAST  = SONG_W'(NUM_SONGS - 1);

	typedef logic [LINE_LEN-1:0][7:0] line_t;
	typedef logic [KW_MAX-1:0][7:0]   kw_t;

	// Element 0 holds the first character of the keyword.
	localparam kw_t KW_HELP  = {8'd0, 8'd0, 8'd0, 8'd0, "P", "L", "E", "H"};
	localparam kw_t KW_PLAY  = {8'd0, 8'd0, 8'd0, 8'd0, "Y", "A", "L", "P"};
	localparam kw_t KW_PAUSE = {8'd0, 8'd0, 8'd0, "E", "S", "U", "A", "P"};
	localparam kw_t KW_NEXT  = {8'd0, 8'd0, 8'd0, 8'd0, "T", "X", "E", "N"};
	localparam kw_t KW_STOP  = {8'd0, 8'd0, 8'd0, 8'd0, "P", "O", "T", "S"};

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] rx_byte;
	} in_beat_t;

	typedef struct packed {
		logic              echo_valid;
		logic [7:0]        echo_char;
		logic [2:0]        action;
		logic [SONG_W-1:0] song_index;
		logic              song_valid;
		logic              led_level;
		logic              blink_mode;
	} out_beat_t;

	// True when the line holds exactly the keyword of the given length.
	function automatic logic kw_match(line_t chars, logic [LEN_W-1:0] len, kw_t kw,
			int kwlen);
		logic ok;
		ok = (kwlen <= LINE_LEN) && (int'(len) == kwlen);
		for (int i = 0; i < LINE_LEN; i++) begin
			if (i < kwlen && i < KW_MAX) begin
				if (chars[i] != kw[i]) begin
					ok = 1'b0;
				end
			end
		end
		return ok;
	endfunction

endpackage

// ----- design/serial_command_line_recognizer.sv -----
// Top level of the serial command-line recognizer: input register, line buffer,
// keyword match, LED and song state, and the result register. Depends on scr_pkg.
//
//  channel | signals                        | contents
//  in      | in_valid, in_ready, in_data    | beat of command and received byte
//  out     | out_valid, out_ready, out_data | beat of echo, action, song and LED state
//  cfg     | cfg_we, cfg_wdata              | write of remote_enable
//
// Each beat is held in the input register and moves to the result register when that register
// is empty or being read; one beat is accepted per cycle while the result is not stalled.
// The line buffer and all state but remote_enable update in the cycle a beat leaves the input register.
// A stalled result holds the input register; reset empties both and sets remote_enable.
module serial_command_line_recognizer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  scr_pkg::in_beat_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output scr_pkg::out_beat_t out_data,
	input  logic              cfg_we,
	input  logic              cfg_wdata
);
	import scr_pkg::*;

	logic              valid_s1;
	in_beat_t          data_s1;
	logic              out_valid_q;
	out_beat_t         out_data_q;

	logic              remote_enable_q;
	line_t             line_q;
	logic [LEN_W-1:0]  len_q;
	logic              blink_q;
	logic              led_q;
	logic              pending_q;
	logic [TICK_W-1:0] tick_q;
	logic [SONG_W-1:0] next_song_q;
	logic [SONG_W-1:0] loaded_song_q;
	logic              song_loaded_q;

	line_t             line_d;
	logic [LEN_W-1:0]  len_d;
	logic              blink_d;
	logic              led_d;
	logic              pending_d;
	logic [TICK_W-1:0] tick_d;
	logic [SONG_W-1:0] next_song_d;
	logic [SONG_W-1:0] loaded_song_d;
	logic              song_loaded_d;
	logic [TICK_W-1:0] tick_inc;
	out_beat_t         result;

	logic advance;
	logic fire;

	assign advance   = !out_valid_q || out_ready;
	assign fire      = valid_s1 && advance;
	assign in_ready  = advance || !valid_s1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign tick_inc  = tick_q + TICK_W'(1);

	always_comb begin
		line_d        = line_q;
		len_d         = len_q;
		blink_d       = blink_q;
		led_d         = led_q;
		pending_d     = pending_q;
		tick_d        = tick_q;
		next_song_d   = next_song_q;
		loaded_song_d = loaded_song_q;
		song_loaded_d = song_loaded_q;
		result        = '0;

		case (data_s1.command)
			CMD_BYTE: begin
				if (remote_enable_q) begin
					if (data_s1.rx_byte == CH_CR) begin
						result.echo_valid = 1'b1;
						result.echo_char  = CH_CR;
						if (kw_match(line_q, len_q, KW_HELP, 4)) begin
							result.action = ACT_HELP;
						end else if (kw_match(line_q, len_q, KW_PLAY, 4)) begin
							result.action = ACT_PLAY;
							blink_d       = 1'b0;
							led_d         = 1'b1;
						end else if (kw_match(line_q, len_q, KW_PAUSE, 5)) begin
							result.action = ACT_PAUSE;
							blink_d       = 1'b1;
						end else if (kw_match(line_q, len_q, KW_NEXT, 4)) begin
							result.action = ACT_LOAD;
							loaded_song_d = next_song_q;
							song_loaded_d = 1'b1;
							if (next_song_q >= SONG_LAST) begin
								next_song_d = '0;
							end else begin
								next_song_d = next_song_q + SONG_W'(1);
							end
						end else if (kw_match(line_q, len_q, KW_STOP, 4)) begin
							result.action = ACT_STOP;
							blink_d       = 1'b0;
							led_d         = 1'b0;
						end else begin
							result.action = ACT_INVALID;
						end
						line_d = '0;
						len_d  = '0;
					end else if (data_s1.rx_byte == CH_DEL) begin
						if (len_q != '0) begin
							len_d = len_q - LEN_W'(1);
							for (int i = 0; i < LINE_LEN; i++) begin
								if (LEN_W'(i) == len_d) begin
									line_d[i] = '0;
								end
							end
							result.echo_valid = 1'b1;
							result.echo_char  = CH_DEL;
						end
					end else if (len_q < LEN_W'(LINE_LEN) && data_s1.rx_byte != CH_NUL) begin
						for (int i = 0; i < LINE_LEN; i++) begin
							if (LEN_W'(i) == len_q) begin
								line_d[i] = data_s1.rx_byte;
							end
						end
						len_d             = len_q + LEN_W'(1);
						result.echo_valid = 1'b1;
						result.echo_char  = data_s1.rx_byte;
					end
				end
			end
			CMD_TICK: begin
				if (tick_inc == TICK_LIMIT) begin
					pending_d = 1'b1;
					tick_d    = '0;
				end else begin
					tick_d = tick_inc;
				end
			end
			CMD_PAUSE: begin
				blink_d = 1'b1;
			end
			CMD_UNPAUSE: begin
				blink_d = 1'b0;
			end
			CMD_PLAY: begin
				result.action = ACT_PLAY;
			end
			default: begin
			end
		endcase

		if (blink_d && pending_d) begin
			led_d     = !led_d;
			pending_d = 1'b0;
		end

		if (result.action == ACT_PLAY || result.action == ACT_LOAD) begin
			result.song_index = loaded_song_d;
		end
		result.song_valid = song_loaded_d;
		result.led_level  = led_d;
		result.blink_mode = blink_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
		if (fire) begin
			out_data_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remote_enable_q <= 1'b1;
			line_q          <= '0;
			len_q           <= '0;
			blink_q         <= 1'b0;
			led_q           <= 1'b0;
			pending_q       <= 1'b0;
			tick_q          <= '0;
			next_song_q     <= '0;
			loaded_song_q   <= '0;
			song_loaded_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				remote_enable_q <= cfg_wdata;
			end
			if (fire) begin
				line_q        <= line_d;
				len_q         <= len_d;
				blink_q       <= blink_d;
				led_q         <= led_d;
				pending_q     <= pending_d;
				tick_q        <= tick_d;
				next_song_q   <= next_song_d;
				loaded_song_q <= loaded_song_d;
				song_loaded_q <= song_loaded_d;
			end
		end
	end

endmodule
